FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the packer RTL.
// Needs signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, masked while in reset
`define YZP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge
`define YZP_NEVER(lbl, expr, msg) `YZP_ASSERT(lbl, !(expr), msg)

`endif

FILE: hw/rtl/yzp_pkg.sv
// Types and constants of the Yaz0 token group packer.
// No dependencies; imported by every packer module.
`default_nettype none

package yzp_pkg;

  // Widths fixed by the largest group (8 tokens of up to 3 bytes)
  localparam int FILL_W     = 5;
  localparam int TOK_W      = 4;
  localparam int MEM_AW     = FILL_W + 1;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;

  localparam logic [31:0] STREAM_TAG = 32'h5961_7A30;
  localparam logic [3:0]  HDR_LAST   = 4'd15;

  localparam logic [8:0]  MATCH_MIN  = 9'd3;
  localparam logic [8:0]  MATCH_LONG = 9'd18;
  localparam logic [8:0]  MATCH_MAX  = 9'd273;
  localparam logic [12:0] DIST_MIN   = 13'd1;
  localparam logic [12:0] DIST_MAX   = 13'd4096;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_MATCH   = 2'd2,
    KIND_FINISH  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_SIZE_MISMATCH = 2'd1,
    ST_BAD_TOKEN     = 2'd2,
    ST_WRONG_ORDER   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_EXPECTED_SIZE = 2'd0,
    CFG_ALIGNMENT     = 2'd1,
    CFG_RESERVED      = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_GROUP  = 2'd1,
    OP_STATUS = 2'd2
  } cmd_op_t;

  // Command handed from the front end to the emitter
  typedef struct packed {
    cmd_op_t             op;
    logic                bank;
    logic [7:0]          flag;
    logic [FILL_W-1:0]   fill;
    status_t             status;
  } cmd_t;

  // Group buffer write port
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  // Emitter tells the front end a buffer bank is free again
  typedef struct packed {
    logic done;
    logic bank;
  } grp_done_t;

endpackage

`default_nettype wire

FILE: hw/rtl/yzp_cmd_fifo.sv
// Short command queue between the packer front end and the emitter.
// Depends on yzp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module yzp_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire yzp_pkg::cmd_t data_in,
  output logic               full,
  input  wire logic          pop,
  output yzp_pkg::cmd_t      data_out,
  output logic               empty
);
  import yzp_pkg::*;

  cmd_t               mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty    = (count_r == '0);
  assign data_out = mem_q[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_q[wr_ptr_r] <= data_in;
    end
  end

  `YZP_ASSERT(a_count_bound, count_r <= (CMDQ_AW+1)'(CMDQ_DEPTH), "command queue overfilled")
  `YZP_NEVER(a_push_full, push && full, "command pushed into full queue")

endmodule

`default_nettype wire

FILE: hw/rtl/yzp_front.sv
// Front end: accepts items, checks order, size and token ranges, packs
// token bytes into the group buffer and issues emitter commands. Uses yzp_pkg.
`default_nettype none
`include "assert_macros.svh"

module yzp_front #(
  parameter int TOKENS_PER_GROUP = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        in_kind,
  input  wire logic [7:0]        in_literal_byte,
  input  wire logic [8:0]        in_match_length,
  input  wire logic [12:0]       in_match_distance,
  input  wire logic [31:0]       expected_size,
  input  wire logic              q_full,
  output logic                   q_push,
  output yzp_pkg::cmd_t          q_data,
  output yzp_pkg::mem_wr_t       mem_wr,
  input  wire yzp_pkg::grp_done_t grp_done
);
  import yzp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_RUN  = 4'b0010,
    PH_DONE = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        flag_r, flag_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [TOK_W-1:0]  tok_r, tok_nxt;
  logic [32:0]       cons_r, cons_nxt;
  logic              bank_r, bank_nxt;
  logic [1:0]        pend_r, pend_nxt;
  // trailing bytes of a match still to be written
  logic [1:0]        wr_left_r, wr_left_nxt;
  logic [FILL_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              wr_bank_r, wr_bank_nxt;
  logic [7:0]        ext0_r, ext0_nxt, ext1_r, ext1_nxt;
  // command held until the group's last byte is written
  logic              hold_r, hold_nxt;
  cmd_t              hold_cmd_r, hold_cmd_nxt;

  logic              accept;
  kind_t             kind;

  assign kind   = kind_t'(in_kind);
  assign full   = (wr_left_r != 2'd0) || q_full || pend_r[bank_r];
  assign accept = push && !full;

  always_comb begin
    logic [12:0]      d13;
    logic [8:0]       lm2, ll;
    logic [8:0]       used;
    logic [32:0]      sum;
    logic [1:0]       nbytes;
    logic [7:0]       b0, b1, b2;
    logic [TOK_W-1:0] tok_new;
    logic [7:0]       flag_new;
    logic [FILL_W-1:0] fill_new;
    logic             bad;
    cmd_t             cmd;

    d13      = in_match_distance - 13'd1;
    lm2      = in_match_length - 9'd2;
    ll       = in_match_length - MATCH_LONG;
    used     = (kind == KIND_LITERAL) ? 9'd1 : in_match_length;
    sum      = cons_r + {24'd0, used};
    bad      = (kind == KIND_MATCH) &&
               (in_match_length < MATCH_MIN || in_match_length > MATCH_MAX ||
                in_match_distance < DIST_MIN || in_match_distance > DIST_MAX);
    tok_new  = tok_r + 1'b1;

    // byte layout of the token
    if (kind == KIND_LITERAL) begin
      nbytes   = 2'd1;
      b0       = in_literal_byte;
      b1       = 8'h00;
      b2       = 8'h00;
      flag_new = flag_r | (8'h80 >> tok_r[2:0]);
    end else if (in_match_length < MATCH_LONG) begin
      nbytes   = 2'd2;
      b0       = {lm2[3:0], d13[11:8]};
      b1       = d13[7:0];
      b2       = 8'h00;
      flag_new = flag_r;
    end else begin
      nbytes   = 2'd3;
      b0       = {4'h0, d13[11:8]};
      b1       = d13[7:0];
      b2       = ll[7:0];
      flag_new = flag_r;
    end
    fill_new = fill_r + {{(FILL_W-2){1'b0}}, nbytes};

    phase_nxt    = phase_r;
    flag_nxt     = flag_r;
    fill_nxt     = fill_r;
    tok_nxt      = tok_r;
    cons_nxt     = cons_r;
    bank_nxt     = bank_r;
    pend_nxt     = pend_r;
    wr_left_nxt  = wr_left_r;
    wr_addr_nxt  = wr_addr_r;
    wr_bank_nxt  = wr_bank_r;
    ext0_nxt     = ext0_r;
    ext1_nxt     = ext1_r;
    hold_nxt     = hold_r;
    hold_cmd_nxt = hold_cmd_r;
    q_push       = 1'b0;
    mem_wr       = '0;

    cmd        = '0;
    cmd.op     = OP_STATUS;
    cmd.status = ST_OK;
    cmd.bank   = bank_r;

    // bank released by the emitter
    if (grp_done.done) begin
      pend_nxt[grp_done.bank] = 1'b0;
    end

    if (accept) begin
      if (kind == KIND_START) begin
        q_push = 1'b1;
        if (phase_r != PH_IDLE) begin
          cmd.status = ST_WRONG_ORDER;
        end else begin
          cmd.op    = OP_HEADER;
          flag_nxt  = 8'h00;
          fill_nxt  = '0;
          tok_nxt   = '0;
          cons_nxt  = '0;
          phase_nxt = PH_RUN;
        end
      end else if (phase_r != PH_RUN) begin
        q_push     = 1'b1;
        cmd.status = ST_WRONG_ORDER;
      end else begin
        case (kind)
          KIND_FINISH: begin
            q_push = 1'b1;
            if (cons_r != {1'b0, expected_size}) begin
              cmd.status = ST_SIZE_MISMATCH;
              phase_nxt  = PH_ERR;
            end else begin
              phase_nxt = PH_DONE;
              if (tok_r != '0) begin
                cmd.op           = OP_GROUP;
                cmd.flag         = flag_r;
                cmd.fill         = fill_r;
                pend_nxt[bank_r] = 1'b1;
                bank_nxt         = !bank_r;
                flag_nxt         = 8'h00;
                fill_nxt         = '0;
                tok_nxt          = '0;
              end
            end
          end
          KIND_LITERAL, KIND_MATCH: begin
            if (bad) begin
              q_push     = 1'b1;
              cmd.status = ST_BAD_TOKEN;
            end else if (sum > {1'b0, expected_size}) begin
              q_push     = 1'b1;
              cmd.status = ST_SIZE_MISMATCH;
              phase_nxt  = PH_ERR;
            end else begin
              cons_nxt    = sum;
              mem_wr.en   = 1'b1;
              mem_wr.addr = {bank_r, fill_r};
              mem_wr.data = b0;
              wr_left_nxt = nbytes - 2'd1;
              wr_addr_nxt = fill_r + 1'b1;
              wr_bank_nxt = bank_r;
              ext0_nxt    = b1;
              ext1_nxt    = b2;
              flag_nxt    = flag_new;
              fill_nxt    = fill_new;
              tok_nxt     = tok_new;
              // group complete: hand it over and switch banks
              if (tok_new >= TOK_W'(TOKENS_PER_GROUP)) begin
                cmd.op           = OP_GROUP;
                cmd.flag         = flag_new;
                cmd.fill         = fill_new;
                pend_nxt[bank_r] = 1'b1;
                bank_nxt         = !bank_r;
                flag_nxt         = 8'h00;
                fill_nxt         = '0;
                tok_nxt          = '0;
                if (nbytes == 2'd1) begin
                  q_push = 1'b1;
                end else begin
                  hold_nxt     = 1'b1;
                  hold_cmd_nxt = cmd;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end else if (wr_left_r != 2'd0) begin
      // trailing match bytes, one per cycle
      mem_wr.en   = 1'b1;
      mem_wr.addr = {wr_bank_r, wr_addr_r};
      mem_wr.data = ext0_r;
      ext0_nxt    = ext1_r;
      wr_addr_nxt = wr_addr_r + 1'b1;
      wr_left_nxt = wr_left_r - 2'd1;
      if (wr_left_r == 2'd1 && hold_r) begin
        q_push   = 1'b1;
        cmd      = hold_cmd_r;
        hold_nxt = 1'b0;
      end
    end

    q_data = cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      flag_r    <= 8'h00;
      fill_r    <= '0;
      tok_r     <= '0;
      cons_r    <= '0;
      bank_r    <= 1'b0;
      pend_r    <= 2'b00;
      wr_left_r <= 2'd0;
      hold_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      flag_r    <= flag_nxt;
      fill_r    <= fill_nxt;
      tok_r     <= tok_nxt;
      cons_r    <= cons_nxt;
      bank_r    <= bank_nxt;
      pend_r    <= pend_nxt;
      wr_left_r <= wr_left_nxt;
      hold_r    <= hold_nxt;
    end
  end

  // Payload of the pending writes
  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    wr_bank_r  <= wr_bank_nxt;
    ext0_r     <= ext0_nxt;
    ext1_r     <= ext1_nxt;
    hold_cmd_r <= hold_cmd_nxt;
  end

  `YZP_ASSERT(a_busy_full, (wr_left_r != 2'd0) |-> full, "item accepted during match write")
  `YZP_ASSERT(a_hold_busy, hold_r |-> (wr_left_r != 2'd0), "held command without pending write")

endmodule

`default_nettype wire

FILE: hw/rtl/yzp_back.sv
// Emitter: runs header, group and status commands; drives the result register
// one byte per cycle if free. Holds the two-bank group buffer. Uses yzp_pkg.
`default_nettype none
`include "assert_macros.svh"

module yzp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire yzp_pkg::cmd_t      q_data,
  output logic                    q_pop,
  input  wire yzp_pkg::mem_wr_t   mem_wr,
  output yzp_pkg::grp_done_t      grp_done,
  input  wire logic [31:0]        expected_size,
  input  wire logic [31:0]        alignment_word,
  input  wire logic [31:0]        reserved_word,
  output logic                    empty,
  input  wire logic               pop,
  output logic [7:0]              out_byte,
  output logic                    out_byte_valid,
  output logic                    out_last,
  output logic [1:0]              out_status
);
  import yzp_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_HDR  = 3'b010,
    B_GRP  = 3'b100
  } bstate_t;

  bstate_t           st_r, st_nxt;
  logic [FILL_W-1:0] j_r, j_nxt;
  logic              bank_r, bank_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              out_full_r, out_full_nxt;
  logic [7:0]        out_byte_r, byte_nxt;
  logic              out_bv_r, bv_nxt;
  logic              out_last_r, last_nxt;
  status_t           out_status_r, status_nxt;
  logic              emit, out_free;
  logic [7:0]        grp_mem [2**MEM_AW];
  logic [7:0]        rd_q;
  logic [MEM_AW-1:0] rd_addr;

  // Header byte j: magic then three big-endian words
  function automatic logic [7:0] hdr_byte(input logic [3:0] j, input logic [31:0] w1,
                                          input logic [31:0] w2, input logic [31:0] w3);
    logic [31:0] w;
    logic [31:0] sh;
    case (j[3:2])
      2'd0:    w = STREAM_TAG;
      2'd1:    w = w1;
      2'd2:    w = w2;
      default: w = w3;
    endcase
    sh = w >> {~j[1:0], 3'b000};
    return sh[7:0];
  endfunction

  assign out_free = !out_full_r || pop;

  always_comb begin
    st_nxt        = st_r;
    j_nxt         = j_r;
    bank_nxt      = bank_r;
    fill_nxt      = fill_r;
    emit          = 1'b0;
    q_pop         = 1'b0;
    byte_nxt      = 8'h00;
    bv_nxt        = 1'b1;
    last_nxt      = 1'b0;
    status_nxt    = ST_OK;
    grp_done      = '0;
    grp_done.bank = bank_r;

    case (st_r)
      B_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          case (q_data.op)
            OP_HEADER: begin
              byte_nxt = hdr_byte(4'd0, expected_size, alignment_word, reserved_word);
              j_nxt    = 5'd1;
              st_nxt   = B_HDR;
            end
            OP_GROUP: begin
              byte_nxt = q_data.flag;
              bank_nxt = q_data.bank;
              fill_nxt = q_data.fill;
              j_nxt    = 5'd1;
              if (q_data.fill == '0) begin
                last_nxt      = 1'b1;
                grp_done.done = 1'b1;
                grp_done.bank = q_data.bank;
              end else begin
                st_nxt = B_GRP;
              end
            end
            default: begin
              bv_nxt     = 1'b0;
              last_nxt   = 1'b1;
              status_nxt = q_data.status;
            end
          endcase
        end
      end
      B_HDR: begin
        if (out_free) begin
          emit     = 1'b1;
          byte_nxt = hdr_byte(j_r[3:0], expected_size, alignment_word, reserved_word);
          j_nxt    = j_r + 1'b1;
          if (j_r[3:0] == HDR_LAST) begin
            last_nxt = 1'b1;
            st_nxt   = B_IDLE;
          end
        end
      end
      B_GRP: begin
        if (out_free) begin
          emit     = 1'b1;
          byte_nxt = rd_q;
          j_nxt    = j_r + 1'b1;
          if (j_r == fill_r) begin
            last_nxt      = 1'b1;
            grp_done.done = 1'b1;
            st_nxt        = B_IDLE;
          end
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase

    out_full_nxt = emit ? 1'b1 : (pop ? 1'b0 : out_full_r);
  end

  // Read data always tracks the byte the next cycle will send
  assign rd_addr = {bank_nxt, j_nxt - 5'd1};

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      grp_mem[mem_wr.addr] <= mem_wr.data;
    end
    rd_q <= grp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= B_IDLE;
      j_r        <= '0;
      out_full_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      j_r        <= j_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  // Result payload and command context
  always_ff @(posedge clk) begin
    bank_r <= bank_nxt;
    fill_r <= fill_nxt;
    if (emit) begin
      out_byte_r   <= byte_nxt;
      out_bv_r     <= bv_nxt;
      out_last_r   <= last_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign empty          = !out_full_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

  `YZP_ASSERT(a_hdr_index, (st_r == B_HDR) |-> (j_r >= 5'd1 && j_r <= 5'd15),
              "header index out of range")
  `YZP_ASSERT(a_grp_index, (st_r == B_GRP) |-> (j_r >= 5'd1 && j_r <= fill_r),
              "group index past fill")

endmodule

`default_nettype wire

FILE: hw/rtl/yaz0_token_group_packer_core.sv
// Yaz0 token group packer top: configuration registers, front end,
// command queue and emitter. Depends on yzp_pkg, yzp_front, yzp_cmd_fifo, yzp_back.
//
// Usage:
//  - Configure expected_size (0), alignment_word (1) and reserved_word (2) on the
//    cfg_ channel while idle; cfg_ready is always high.
//  - Items go in as a queue: push with full low. kind 0 starts a stream and
//    yields the 16-byte header, 1/2 pack a literal or match into the current
//    group, 3 finishes and flushes a partial group.
//  - Results come out as a queue: while empty is low the oldest result is on the
//    out_ ports, taken with pop. Status-only results carry out_byte_valid low.
//  - A group-ending match issues its group command after its trailing bytes are written.
//  - A literal's byte is written on accept; a match's further bytes follow through the
//    single write port of the group buffer, and full stays high until they are written.
//    Results drain at one byte per cycle from the emitter while the receiver pops.
//  - full also rises while the command queue is full or the group buffer bank
//    about to be filled is still being emitted.
//  - A stalled receiver holds the result register; the emitter and then the
//    queue back up and full rises. Nothing is lost.
//  - Synchronous reset clears the registers, the stream phase and the queues.
//    No clearing pass is needed.
`default_nettype none

module yaz0_token_group_packer_core #(
  parameter int TOKENS_PER_GROUP = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // item channel
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_literal_byte,
  input  wire logic [8:0]  in_match_length,
  input  wire logic [12:0] in_match_distance,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_last,
  output logic [1:0]       out_status,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import yzp_pkg::*;

  logic [31:0] expected_size_r, alignment_word_r, reserved_word_r;
  logic        q_full, q_push, q_pop, q_empty;
  cmd_t        q_in, q_out;
  mem_wr_t     mem_wr;
  grp_done_t   grp_done;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_size_r  <= '0;
      alignment_word_r <= '0;
      reserved_word_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_EXPECTED_SIZE: expected_size_r  <= cfg_data;
        CFG_ALIGNMENT:     alignment_word_r <= cfg_data;
        CFG_RESERVED:      reserved_word_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  yzp_front #(
    .TOKENS_PER_GROUP(TOKENS_PER_GROUP)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_kind          (in_kind),
    .in_literal_byte  (in_literal_byte),
    .in_match_length  (in_match_length),
    .in_match_distance(in_match_distance),
    .expected_size    (expected_size_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in),
    .mem_wr           (mem_wr),
    .grp_done         (grp_done)
  );

  yzp_cmd_fifo u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .data_in (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .data_out(q_out),
    .empty   (q_empty)
  );

  yzp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .mem_wr        (mem_wr),
    .grp_done      (grp_done),
    .expected_size (expected_size_r),
    .alignment_word(alignment_word_r),
    .reserved_word (reserved_word_r),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_byte_valid(out_byte_valid),
    .out_last      (out_last),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

FILE: verif/tb_yaz0_token_group_packer_core.sv
// Self-checking testbench for yaz0_token_group_packer_core.
// Needs yzp_pkg; a built-in predictor computes the expected stream byte by byte.
module tb_yaz0_token_group_packer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import yzp_pkg::*;

  localparam int GROUP_TOKENS = 8;
  localparam int QUIET_LIMIT  = 4000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_CYC   = 12;
  localparam int MAX_PRINTS   = 60;

  typedef enum logic [1:0] {SP_IDLE, SP_RUN, SP_DONE, SP_ERR} stream_phase_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  lit;
    logic [8:0]  len;
    logic [12:0] mdist;
  } token_t;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       last;
    status_t    status;
  } stream_byte_t;

  // DUT connections
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_kind = KIND_START;
  logic [7:0]  in_literal_byte = 8'h00;
  logic [8:0]  in_match_length = 9'd0;
  logic [12:0] in_match_distance = 13'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_last;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_EXPECTED_SIZE;
  logic [31:0] cfg_data = 32'd0;

  yaz0_token_group_packer_core #(.TOKENS_PER_GROUP(GROUP_TOKENS)) dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_kind(in_kind), .in_literal_byte(in_literal_byte),
    .in_match_length(in_match_length), .in_match_distance(in_match_distance),
    .empty(empty), .pop(pop),
    .out_byte(out_byte), .out_byte_valid(out_byte_valid),
    .out_last(out_last), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stimulus and expectation stores
  token_t       token_backlog[$];
  stream_byte_t expected_stream[$];
  int           errors = 0;
  int           send_idle_pct = 17;
  int           recv_idle_pct = 87;
  int           hold_trigger = 0;
  int           hold_taken = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;
  bit           offer_taken = 1'b0;

  // Packer state as the predictor sees it
  logic [31:0]       pk_size = 32'd0;
  logic [31:0]       pk_align = 32'd0;
  logic [31:0]       pk_resv = 32'd0;
  logic [7:0]        pk_flag = 8'd0;
  logic [7:0]        pk_group[24];
  int                pk_fill = 0;
  int                pk_tokens = 0;
  longint unsigned   pk_consumed = 0;
  stream_phase_t     pk_phase = SP_IDLE;

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic expect_byte(input logic [7:0] b, input logic v, input logic l,
                             input status_t st);
    stream_byte_t r;
    r.data = b; r.valid = v; r.last = l; r.status = st;
    expected_stream.push_back(r);
  endtask

  task automatic store_group_byte(input logic [7:0] b);
    if (pk_fill < 24) pk_group[pk_fill] = b;
    pk_fill++;
  endtask

  // Flag byte then the group bytes, last marks the final one
  task automatic flush_group();
    for (int i = 0; i <= pk_fill; i++)
      expect_byte((i == 0) ? pk_flag : pk_group[i-1], 1'b1, i == pk_fill, ST_OK);
    pk_flag = 8'd0;
    pk_fill = 0;
    pk_tokens = 0;
  endtask

  // Works out the results of one accepted item and advances the state
  task automatic pack_item(input kind_t kind, input logic [7:0] lit,
                           input logic [8:0] len, input logic [12:0] mdist);
    logic [127:0]    hdr;
    logic [12:0]     d;
    logic [8:0]      code;
    longint unsigned used;
    if (kind == KIND_START) begin
      if (pk_phase != SP_IDLE) begin
        expect_byte(8'd0, 1'b0, 1'b1, ST_WRONG_ORDER);
        return;
      end
      hdr = {STREAM_TAG, pk_size, pk_align, pk_resv};
      for (int i = 0; i < 16; i++)
        expect_byte(hdr[127 - 8*i -: 8], 1'b1, i == 15, ST_OK);
      pk_flag = 8'd0; pk_fill = 0; pk_tokens = 0;
      pk_consumed = 0;
      pk_phase = SP_RUN;
      return;
    end
    if (pk_phase != SP_RUN) begin
      expect_byte(8'd0, 1'b0, 1'b1, ST_WRONG_ORDER);
      return;
    end
    if (kind == KIND_FINISH) begin
      if (pk_consumed != longint'(pk_size)) begin
        pk_phase = SP_ERR;
        expect_byte(8'd0, 1'b0, 1'b1, ST_SIZE_MISMATCH);
      end else begin
        pk_phase = SP_DONE;
        if (pk_tokens == 0) expect_byte(8'd0, 1'b0, 1'b1, ST_OK);
        else flush_group();
      end
      return;
    end
    // literal or match token
    if (kind == KIND_MATCH && (len < MATCH_MIN || len > MATCH_MAX ||
                               mdist < DIST_MIN || mdist > DIST_MAX)) begin
      expect_byte(8'd0, 1'b0, 1'b1, ST_BAD_TOKEN);
      return;
    end
    used = (kind == KIND_LITERAL) ? 64'd1 : 64'(len);
    if (pk_consumed + used > longint'(pk_size)) begin
      pk_phase = SP_ERR;
      expect_byte(8'd0, 1'b0, 1'b1, ST_SIZE_MISMATCH);
      return;
    end
    pk_consumed += used;
    if (kind == KIND_LITERAL) begin
      store_group_byte(lit);
      pk_flag = pk_flag | (8'h80 >> pk_tokens[2:0]);
    end else begin
      d = mdist - 13'd1;
      if (len < MATCH_LONG) begin
        code = len - 9'd2;
        store_group_byte({code[3:0], d[11:8]});
        store_group_byte(d[7:0]);
      end else begin
        code = len - MATCH_LONG;
        store_group_byte({4'd0, d[11:8]});
        store_group_byte(d[7:0]);
        store_group_byte(code[7:0]);
      end
    end
    pk_tokens++;
    if (pk_tokens >= GROUP_TOKENS) flush_group();
  endtask

  function automatic token_t token_of(input kind_t k, input logic [7:0] l,
                                      input logic [8:0] n, input logic [12:0] d);
    token_t t;
    t.kind = k; t.lit = l; t.len = n; t.mdist = d;
    return t;
  endfunction

  // Mostly well-formed tokens, some malformed matches, the odd stray start
  function automatic token_t draw_running_token();
    int     r;
    token_t t;
    r = $urandom_range(99);
    t = token_of(KIND_LITERAL, 8'($urandom_range(255)), 9'($urandom_range(511)),
                 13'($urandom_range(8191)));
    if (r >= 45 && r < 80) begin
      t.kind = KIND_MATCH;
      t.len  = ($urandom_range(1) == 0) ? 9'($urandom_range(3, 17)) :
                                          9'($urandom_range(18, 273));
      case ($urandom_range(9))
        0:       t.mdist = DIST_MIN;
        1:       t.mdist = DIST_MAX;
        default: t.mdist = 13'($urandom_range(1, 4096));
      endcase
    end else if (r >= 80 && r < 95) begin
      t.kind = KIND_MATCH;
    end else if (r >= 95) begin
      t.kind = KIND_START;
    end
    return t;
  endfunction

  // Sender side: a held offer stays until the block takes it
  always @(negedge clk) begin
    if (!push || offer_taken) begin
      if (token_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push              <= 1'b1;
        in_kind           <= token_backlog[0].kind;
        in_literal_byte   <= token_backlog[0].lit;
        in_match_length   <= token_backlog[0].len;
        in_match_distance <= token_backlog[0].mdist;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver side, with the occasional long hold-off
  always @(negedge clk) begin
    if (hold_trigger != hold_taken) begin
      hold_taken <= hold_trigger;
      hold_left  <= LONG_HOLD;
      pop        <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: register writes, accepted items, accepted results, watchdog
  always @(posedge clk) begin
    stream_byte_t want;
    bit           moved;
    if (!rst_n) begin
      offer_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_idx_t'(cfg_index))
          CFG_EXPECTED_SIZE: pk_size  = cfg_data;
          CFG_ALIGNMENT:     pk_align = cfg_data;
          CFG_RESERVED:      pk_resv  = cfg_data;
          default: ;
        endcase
      end
      offer_taken = push && !full;
      if (offer_taken) begin
        moved = 1'b1;
        pack_item(kind_t'(in_kind), in_literal_byte, in_match_length, in_match_distance);
        void'(token_backlog.pop_front());
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (expected_stream.size() == 0) begin
          report_mismatch($sformatf("result byte %0h with nothing expected", out_byte));
        end else begin
          want = expected_stream.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %0h, want %0h", out_byte, want.data));
          if (out_byte_valid !== want.valid)
            report_mismatch($sformatf("out_byte_valid %0b, want %0b",
                                      out_byte_valid, want.valid));
          if (out_last !== want.last)
            report_mismatch($sformatf("out_last %0b, want %0b", out_last, want.last));
          if (out_status !== want.status)
            report_mismatch($sformatf("out_status %0d, want %0d", out_status, want.status));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_yaz0_token_group_packer_core: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender pause: everything taken, every result back, front end settled
  task automatic wait_drained();
    while (token_backlog.size() != 0 || expected_stream.size() != 0 || push)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic wait_backlog_taken();
    while (token_backlog.size() != 0) @(posedge clk);
  endtask

  initial begin
    int ending;
    int k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extremes written while idle; tokens before a start are out of order
    write_reg(CFG_EXPECTED_SIZE, 32'd0);
    write_reg(CFG_ALIGNMENT, 32'hFFFF_FFFF);
    write_reg(CFG_RESERVED, 32'd0);
    token_backlog.push_back(token_of(KIND_LITERAL, 8'hA5, 9'd0, 13'd0));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd3, 13'd1));
    token_backlog.push_back(token_of(KIND_FINISH, 8'h00, 9'd0, 13'd0));
    wait_drained();

    write_reg(CFG_EXPECTED_SIZE, 32'hFFFF_FFFF);
    write_reg(CFG_ALIGNMENT, $urandom);
    write_reg(CFG_RESERVED, 32'hFFFF_FFFF);

    // Header, length and distance extremes, malformed matches, stray start
    token_backlog.push_back(token_of(KIND_START, 8'h00, 9'd0, 13'd0));
    token_backlog.push_back(token_of(KIND_LITERAL, 8'h00, 9'd511, 13'd8191));
    token_backlog.push_back(token_of(KIND_LITERAL, 8'hFF, 9'd0, 13'd0));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd3, 13'd1));
    token_backlog.push_back(token_of(KIND_MATCH, 8'hFF, 9'd17, 13'd4096));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd18, 13'd2));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd273, 13'd4096));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd2, 13'd1));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd274, 13'd1));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd3, 13'd0));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd3, 13'd4097));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd511, 13'd8191));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd0, 13'd0));
    token_backlog.push_back(token_of(KIND_START, 8'h00, 9'd0, 13'd0));
    token_backlog.push_back(token_of(KIND_LITERAL, 8'h5A, 9'd0, 13'd0));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd100, 13'd2048));
    wait_backlog_taken();

    // Random tokens, slow receiver
    repeat (80) token_backlog.push_back(draw_running_token());
    wait_drained();

    // New header words and a mid-range size limit between phases
    write_reg(CFG_ALIGNMENT, $urandom);
    write_reg(CFG_RESERVED, $urandom);
    write_reg(CFG_EXPECTED_SIZE, 32'(pk_consumed + 200000));

    // Random tokens, slow sender
    send_idle_pct = 87;
    recv_idle_pct = 17;
    repeat (80) token_backlog.push_back(draw_running_token());
    wait_backlog_taken();

    // Full speed; receiver holds off long enough for full to rise
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_trigger = hold_trigger + 1;
    repeat (70) token_backlog.push_back(draw_running_token());
    wait_drained();

    // Close the stream one of four ways
    ending = $urandom_range(3);
    case (ending)
      0: begin // flush of a partial group
        write_reg(CFG_EXPECTED_SIZE, 32'(pk_consumed + 1));
        token_backlog.push_back(token_of(KIND_LITERAL, 8'($urandom_range(255)), 9'd0,
                                         13'd0));
        token_backlog.push_back(token_of(KIND_FINISH, 8'h00, 9'd0, 13'd0));
      end
      1: begin // finish with bytes missing
        write_reg(CFG_EXPECTED_SIZE, 32'(pk_consumed + 5));
        token_backlog.push_back(token_of(KIND_FINISH, 8'h00, 9'd0, 13'd0));
      end
      2: begin // token past the size limit
        write_reg(CFG_EXPECTED_SIZE, 32'(pk_consumed));
        token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd3, 13'd1));
        token_backlog.push_back(token_of(KIND_FINISH, 8'h00, 9'd0, 13'd0));
      end
      default: begin // fill the group exactly, then finish with nothing pending
        k = (GROUP_TOKENS - pk_tokens) % GROUP_TOKENS;
        write_reg(CFG_EXPECTED_SIZE, 32'(pk_consumed + k));
        repeat (k)
          token_backlog.push_back(token_of(KIND_LITERAL, 8'($urandom_range(255)), 9'd0,
                                           13'd0));
        token_backlog.push_back(token_of(KIND_FINISH, 8'h00, 9'd0, 13'd0));
      end
    endcase

    // Anything after the stream has closed is out of order
    token_backlog.push_back(token_of(KIND_START, 8'h00, 9'd0, 13'd0));
    token_backlog.push_back(token_of(KIND_LITERAL, 8'h3C, 9'd0, 13'd0));
    token_backlog.push_back(token_of(KIND_MATCH, 8'h00, 9'd20, 13'd7));
    token_backlog.push_back(token_of(KIND_FINISH, 8'h00, 9'd0, 13'd0));
    repeat (6)
      token_backlog.push_back(token_of(kind_t'($urandom_range(3)),
                                       8'($urandom_range(255)),
                                       9'($urandom_range(511)),
                                       13'($urandom_range(8191))));
    wait_drained();
    repeat (20) @(posedge clk);

    if (expected_stream.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_stream.size()));
    if (errors == 0) begin
      $display("tb_yaz0_token_group_packer_core: clean");
    end else begin
      $display("tb_yaz0_token_group_packer_core: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/yzp_pkg.sv
hw/rtl/yzp_cmd_fifo.sv
hw/rtl/yzp_front.sv
hw/rtl/yzp_back.sv
hw/rtl/yaz0_token_group_packer_core.sv
verif/tb_yaz0_token_group_packer_core.sv
